// ----- src/mie_pkg.sv -----
// Package for the modular inverse block: sequencer state type.
// No dependencies; imported by the top level.
package mie_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_SUB,
		ST_FINAL
	} mie_state_t;

endpackage

// ----- src/mie_alu.sv -----
// Shared compare and subtract unit of the modular inverse block.
// Purely combinational; no package dependency.
module mie_alu #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             ge,
	output logic [WIDTH-1:0] diff
);

	logic [WIDTH:0] ext_diff;

	// Subtract with one extra bit; a clear borrow means a >= b
	assign ext_diff = {1'b0, a} - {1'b0, b};
	assign ge       = ~ext_diff[WIDTH];
	assign diff     = ext_diff[WIDTH-1:0];

endmodule

// ----- src/modular_inverse_ext_euclid.sv -----
// Modular inverse by extended Euclid, one shift-subtract step per cycle on the shared compare
// unit; each round doubles the divisor up under r0, then subtracts one quotient bit at a time.
// A new word is taken only in idle, after the last one is done; the next word is taken while
// the last result still waits at the output register.
// Reset: arst_n clears the sequencer and the output valid; data registers are not reset.
module modular_inverse_ext_euclid
	import mie_pkg::*;
#(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] inverse,
	output logic             no_inverse
);

	localparam int KW = $clog2(WIDTH);

	mie_state_t state_q, state_d;

	logic [WIDTH-1:0] r0_q, r1_q, c0_q, c1_q, d_q, cm_q, mod_q;
	logic [KW-1:0]    k_q;
	logic             odd_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] inverse_q;
	logic             no_inverse_q;

	logic [WIDTH-1:0] alu_a, alu_b, alu_diff;
	logic             alu_ge;
	logic [WIDTH-1:0] c_sum;
	logic             can_shift;
	logic             load_out;

	// Operand select for the shared compare/subtract unit
	always_comb begin
		if (state_q == ST_FINAL) begin
			alu_a = mod_q;
			alu_b = c0_q;
		end else if (state_q == ST_ALIGN) begin
			alu_a = r0_q;
			alu_b = {d_q[WIDTH-2:0], 1'b0};
		end else begin
			alu_a = r0_q;
			alu_b = d_q;
		end
	end

	mie_alu #(
		.WIDTH(WIDTH)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.ge  (alu_ge),
		.diff(alu_diff)
	);

	// Cofactor accumulate: c0 collects c0 + q * c1 one quotient bit at a time
	assign c_sum     = c0_q + cm_q;
	assign can_shift = ~d_q[WIDTH-1] & alu_ge;
	assign load_out  = (state_q == ST_FINAL) && (!out_valid_q || out_ready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (r1_q == '0) ? ST_FINAL : ST_ALIGN;
			end
			ST_ALIGN: begin
				if (!can_shift) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				if (k_q == '0) begin
					state_d = ST_CHECK;
				end
			end
			ST_FINAL: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Euclid datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					r0_q  <= value;
					r1_q  <= modulus;
					mod_q <= modulus;
					c0_q  <= {{(WIDTH-1){1'b0}}, 1'b1};
					c1_q  <= '0;
					odd_q <= 1'b0;
				end
			end
			ST_CHECK: begin
				d_q  <= r1_q;
				cm_q <= c1_q;
				k_q  <= '0;
			end
			ST_ALIGN: begin
				// Double divisor and cofactor multiple while it still fits under r0
				if (can_shift) begin
					d_q  <= {d_q[WIDTH-2:0], 1'b0};
					cm_q <= {cm_q[WIDTH-2:0], 1'b0};
					k_q  <= k_q + 1'b1;
				end
			end
			ST_SUB: begin
				if (k_q == '0) begin
					// Last quotient bit: swap into the next round
					r0_q  <= r1_q;
					r1_q  <= alu_ge ? alu_diff : r0_q;
					c0_q  <= c1_q;
					c1_q  <= alu_ge ? c_sum : c0_q;
					odd_q <= ~odd_q;
				end else begin
					if (alu_ge) begin
						r0_q <= alu_diff;
						c0_q <= c_sum;
					end
					d_q  <= {1'b0, d_q[WIDTH-1:1]};
					cm_q <= {1'b0, cm_q[WIDTH-1:1]};
					k_q  <= k_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (r0_q != {{(WIDTH-1){1'b0}}, 1'b1}) begin
				inverse_q    <= '0;
				no_inverse_q <= 1'b1;
			end else begin
				inverse_q    <= odd_q ? alu_diff : c0_q;
				no_inverse_q <= 1'b0;
			end
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign inverse    = inverse_q;
	assign no_inverse = no_inverse_q;

`ifndef SYNTHESIS
	a_no_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_inverse |-> inverse == '0)
		else $error("no_inverse result carries nonzero inverse");

	a_last_bit_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUB && k_q == '0 |-> d_q == r1_q && cm_q == c1_q)
		else $error("divisor not back at r1 on last quotient bit");

	a_align_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALIGN |-> r1_q != '0)
		else $error("division started with zero divisor");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK)
		else $error("accepted word did not start a round");
`endif

endmodule
